@@ hw/rtl/mcpi_pkg.sv @@
// Shared types, constants and fixed-point settings of the motor current PI block.
`default_nettype none

package mcpi_pkg;

    // Fixed-point layout
    localparam int GAIN_FRAC_BITS = 16;
    localparam int ACCUM_WIDTH    = 48;
    localparam int GAIN_W         = 24;
    localparam int ERR_W          = 9;
    localparam int PROD_W         = GAIN_W + 2 + ERR_W;
    localparam int SUM_W          = ACCUM_WIDTH + 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Mode byte codes and transmit codes
    localparam logic [7:0] MODE_AUTO      = 8'h10;
    localparam logic [7:0] MODE_MANUAL    = 8'h20;
    localparam logic [7:0] MODE_FAIL      = 8'h30;
    localparam logic [7:0] TX_ACK         = 8'hBB;
    localparam logic [7:0] TX_FAIL        = 8'h11;
    localparam logic [7:0] SETPOINT_RESET = 8'd15;

    // Gain reset values: round(k * 2^GAIN_FRAC_BITS)
    localparam longint unsigned KP_RESET_L =
        ((64'd1040 << GAIN_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam longint unsigned KI_RESET_L =
        ((64'd67 << GAIN_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(KP_RESET_L);
    localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(KI_RESET_L);

    // Accumulator clamp points
    localparam logic signed [ACCUM_WIDTH-1:0] ACC_ONE = ACCUM_WIDTH'(64'd1 << GAIN_FRAC_BITS);
    localparam logic signed [ACCUM_WIDTH-1:0] ACC_TOP = ACCUM_WIDTH'(64'd256 << GAIN_FRAC_BITS);
    localparam logic signed [ACCUM_WIDTH-1:0] ACC_255 = ACCUM_WIDTH'(64'd255 << GAIN_FRAC_BITS);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_Q_CUR,
        OP_Q_SPD,
        OP_Q_TMP,
        OP_Q_MODE,
        OP_SET_KP,
        OP_SET_KI,
        OP_SET_MODE,
        OP_SET_SETPT,
        OP_SET_DUTY
    } op_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [7:0] current_sample;
        logic [7:0] speed_sample;
        logic [7:0] temp_sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] duty;
        logic [7:0] tx_byte;
        logic       led_on;
        logic       blink_alarm;
    } result_t;

    // Classified item as it travels through the queue
    typedef struct packed {
        logic       is_tick;
        logic       is_query;
        op_t        op;
        logic [7:0] rx_byte;
        logic [7:0] current_sample;
        logic [7:0] speed_sample;
        logic [7:0] temp_sample;
    } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/mcpi_front.sv @@
// Front stage: accept items, decode command bytes and hold one classified entry.
`default_nettype none

module mcpi_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mcpi_pkg::in_item_t in_data,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output mcpi_pkg::entry_t       push_data
);
    import mcpi_pkg::*;

    localparam logic [7:0] CMD_Q_CUR    = 8'h01;
    localparam logic [7:0] CMD_Q_SPD    = 8'h02;
    localparam logic [7:0] CMD_SET_KP   = 8'h05;
    localparam logic [7:0] CMD_SET_KI   = 8'h06;
    localparam logic [7:0] CMD_SET_MODE = 8'h07;
    localparam logic [7:0] CMD_SETPT    = 8'h08;
    localparam logic [7:0] CMD_SET_DUTY = 8'h0A;
    localparam logic [7:0] CMD_Q_MODE   = 8'h0B;
    localparam logic [7:0] CMD_Q_TMP    = 8'h0C;

    logic   entry_valid_reg;
    entry_t entry_reg;
    entry_t entry_next;

    // Speed loop and unknown headers decode to OP_NONE: acknowledge only
    always_comb
    begin
        entry_next.is_tick        = in_data.mode;
        entry_next.rx_byte        = in_data.rx_byte;
        entry_next.current_sample = in_data.current_sample;
        entry_next.speed_sample   = in_data.speed_sample;
        entry_next.temp_sample    = in_data.temp_sample;
        unique case (in_data.rx_byte)
            CMD_Q_CUR:    entry_next.op = OP_Q_CUR;
            CMD_Q_SPD:    entry_next.op = OP_Q_SPD;
            CMD_Q_TMP:    entry_next.op = OP_Q_TMP;
            CMD_Q_MODE:   entry_next.op = OP_Q_MODE;
            CMD_SET_KP:   entry_next.op = OP_SET_KP;
            CMD_SET_KI:   entry_next.op = OP_SET_KI;
            CMD_SET_MODE: entry_next.op = OP_SET_MODE;
            CMD_SETPT:    entry_next.op = OP_SET_SETPT;
            CMD_SET_DUTY: entry_next.op = OP_SET_DUTY;
            default:      entry_next.op = OP_NONE;
        endcase
        entry_next.is_query = (entry_next.op == OP_Q_CUR) || (entry_next.op == OP_Q_SPD)
                           || (entry_next.op == OP_Q_TMP) || (entry_next.op == OP_Q_MODE);
    end

    assign in_ready   = !entry_valid_reg || push_ready;
    assign push_valid = entry_valid_reg;
    assign push_data  = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            entry_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mcpi_queue.sv @@
// Short entry queue between the decode front and the execution back.
`default_nettype none

module mcpi_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire mcpi_pkg::entry_t push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output mcpi_pkg::entry_t      pop_data
);
    import mcpi_pkg::*;

    entry_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg;
    logic [QPTR_W-1:0]   tail_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[head_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                tail_reg <= QPTR_W'(tail_reg + 1'b1);
            end
            if (do_pop)
            begin
                head_reg <= QPTR_W'(head_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mcpi_back.sv @@
// Execution back end: parser state, PI sequencer, mode handling and result register.
`default_nettype none

module mcpi_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire mcpi_pkg::entry_t pop_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mcpi_pkg::result_t     out_data
);
    import mcpi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_CLAMP
    } state_t;

    state_t state_reg, state_next;

    // Architectural state
    logic [7:0]                     mode_byte_reg, mode_byte_next;
    logic                           await_reg, await_next;
    op_t                            hdr_reg, hdr_next;
    logic [7:0]                     setpt_reg, setpt_next;
    logic [GAIN_W-1:0]              kp_reg, kp_next;
    logic [GAIN_W-1:0]              ki_reg, ki_next;
    logic signed [ERR_W-1:0]        last_err_reg, last_err_next;
    logic signed [ACCUM_WIDTH-1:0]  acc_reg, acc_next;
    logic [7:0]                     duty_set_reg, duty_set_next;
    logic [7:0]                     tx_reg, tx_next;
    logic                           led_reg, led_next;
    logic [7:0]                     driven_reg, driven_next;

    // PI datapath
    logic signed [ERR_W-1:0]        err_reg, err_next;
    logic signed [PROD_W-1:0]       p1_reg, p1_next;
    logic signed [PROD_W-1:0]       p2_reg, p2_next;
    logic signed [ACCUM_WIDTH-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]        sum_wide;
    logic [GAIN_W:0]                k_sum;

    // Result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic    out_free;
    logic    auto_tick;
    logic    alarm;
    op_t     run_op;
    logic [7:0] arg;

    assign out_free  = !out_valid_reg || out_ready;
    assign auto_tick = pop_data.is_tick && (mode_byte_reg == MODE_AUTO);
    assign pop_ready = (state_reg == S_IDLE) && (auto_tick || out_free);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign k_sum     = {1'b0, kp_reg} + {1'b0, ki_reg};

    always_comb
    begin
        state_next     = state_reg;
        mode_byte_next = mode_byte_reg;
        await_next     = await_reg;
        hdr_next       = hdr_reg;
        setpt_next     = setpt_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        last_err_next  = last_err_reg;
        acc_next       = acc_reg;
        duty_set_next  = duty_set_reg;
        tx_next        = tx_reg;
        led_next       = led_reg;
        driven_next    = driven_reg;
        err_next       = err_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        alarm          = 1'b0;
        run_op         = OP_NONE;
        arg            = 8'd0;
        sum_wide       = SUM_W'(acc_reg) + SUM_W'(p1_reg) - SUM_W'(p2_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid && auto_tick)
                begin
                    err_next   = ERR_W'({1'b0, setpt_reg}) - ERR_W'({1'b0, pop_data.current_sample});
                    state_next = S_MUL;
                end
                else if (pop_valid && out_free)
                begin
                    if (!pop_data.is_tick)
                    begin
                        tx_next = TX_ACK;
                        if (!await_reg)
                        begin
                            hdr_next   = pop_data.op;
                            await_next = 1'b1;
                            run_op     = pop_data.is_query ? pop_data.op : OP_NONE;
                        end
                        else
                        begin
                            await_next = 1'b0;
                            run_op     = hdr_reg;
                            arg        = pop_data.rx_byte;
                        end
                        unique case (run_op)
                            OP_Q_CUR:     tx_next        = pop_data.current_sample;
                            OP_Q_SPD:     tx_next        = pop_data.speed_sample;
                            OP_Q_TMP:     tx_next        = pop_data.temp_sample;
                            OP_Q_MODE:    tx_next        = mode_byte_reg;
                            OP_SET_KP:    kp_next        = GAIN_W'(32'(arg) << GAIN_FRAC_BITS);
                            OP_SET_KI:    ki_next        = GAIN_W'(32'(arg) << GAIN_FRAC_BITS);
                            OP_SET_MODE:  mode_byte_next = arg;
                            OP_SET_SETPT: setpt_next     = arg;
                            OP_SET_DUTY:  duty_set_next  = arg;
                            default:      ;
                        endcase
                    end
                    else
                    begin
                        unique case (mode_byte_reg)
                            MODE_MANUAL:
                            begin
                                driven_next = duty_set_reg;
                                led_next    = 1'b1;
                            end
                            MODE_FAIL:
                            begin
                                driven_next   = 8'd0;
                                last_err_next = '0;
                                tx_next       = TX_FAIL;
                            end
                            default:
                            begin
                                alarm    = 1'b1;
                                led_next = 1'b0;
                            end
                        endcase
                    end
                    out_valid_next       = 1'b1;
                    out_next.duty        = driven_next;
                    out_next.tx_byte     = tx_next;
                    out_next.led_on      = led_next;
                    out_next.blink_alarm = alarm;
                end
            end
            S_MUL:
            begin
                p1_next    = PROD_W'($signed({1'b0, k_sum})) * PROD_W'(err_reg);
                p2_next    = PROD_W'($signed({2'b00, kp_reg})) * PROD_W'(last_err_reg);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // saturate to the signed accumulator range
                if (sum_wide[SUM_W-1] != sum_wide[SUM_W-2])
                begin
                    sum_next = sum_wide[SUM_W-1] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                                                 : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
                end
                else
                begin
                    sum_next = sum_wide[ACCUM_WIDTH-1:0];
                end
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (out_free)
                begin
                    if (sum_reg >= ACC_TOP)
                    begin
                        driven_next = 8'd255;
                        acc_next    = ACC_255;
                    end
                    else if (sum_reg < ACC_ONE)
                    begin
                        driven_next = 8'd1;
                        acc_next    = ACC_ONE;
                    end
                    else
                    begin
                        driven_next = sum_reg[GAIN_FRAC_BITS +: 8];
                        acc_next    = sum_reg;
                    end
                    duty_set_next        = driven_next;
                    last_err_next        = err_reg;
                    out_valid_next       = 1'b1;
                    out_next.duty        = driven_next;
                    out_next.tx_byte     = tx_reg;
                    out_next.led_on      = led_reg;
                    out_next.blink_alarm = 1'b0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_byte_reg <= MODE_MANUAL;
            await_reg     <= 1'b0;
            hdr_reg       <= OP_NONE;
            setpt_reg     <= SETPOINT_RESET;
            kp_reg        <= KP_RESET;
            ki_reg        <= KI_RESET;
            last_err_reg  <= '0;
            acc_reg       <= '0;
            duty_set_reg  <= 8'd0;
            tx_reg        <= TX_ACK;
            led_reg       <= 1'b0;
            driven_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_byte_reg <= mode_byte_next;
            await_reg     <= await_next;
            hdr_reg       <= hdr_next;
            setpt_reg     <= setpt_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            last_err_reg  <= last_err_next;
            acc_reg       <= acc_next;
            duty_set_reg  <= duty_set_next;
            tx_reg        <= tx_next;
            led_reg       <= led_next;
            driven_reg    <= driven_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        sum_reg <= sum_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/motor_current_pi_with_command_parser_core.sv @@
// Top level of the motor current PI controller with serial command parser.
//
//  channel | signals                       | carries
//  --------+-------------------------------+-----------------------------------------
//  in      | in_valid, in_ready, in_data   | serial byte or control tick with samples
//  out     | out_valid, out_ready, out_data| duty, transmit byte, LED, blink alarm
//
// A transfer on in is decoded and registered in the front stage, then parked in a
// four-entry queue. The back end takes one entry per cycle while the out channel is
// free, for bytes and for manual, fail or unknown-mode ticks; an auto-mode tick runs
// the PI sequencer (error, multiply, accumulate with saturation, clamp and commit).
// Reset loads manual mode, setpoint 15, the default gains and transmit byte 0xBB.
// A stalled out channel holds the result register; the back end then waits, and
// the queue keeps absorbing input transfers until it fills.
`default_nettype none

module motor_current_pi_with_command_parser_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mcpi_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mcpi_pkg::result_t       out_data
);
    import mcpi_pkg::*;

    // Front to queue
    logic   fq_valid;
    logic   fq_ready;
    entry_t fq_data;

    // Queue to back
    logic   qb_valid;
    logic   qb_ready;
    entry_t qb_data;

    // Decode command bytes, hold one entry
    mcpi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data)
    );

    // Decouple decode from execution
    mcpi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // Execute commands and control ticks, drive the result register
    mcpi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (qb_valid),
        .pop_ready (qb_ready),
        .pop_data  (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTH
    // An accepted transfer always lands in the front register
    a_front_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> fq_valid)
        else $error("front stage lost an accepted transfer");

    // A pushed entry leaves the queue non-empty
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fq_valid && fq_ready |=> qb_valid)
        else $error("queue empty after push");

    // The blink alarm always ends with the LED dark
    a_alarm_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.blink_alarm |-> !out_data.led_on)
        else $error("blink alarm with LED lit");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the motor current PI controller and its command parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcpi_pkg::*;

    // Parser header bytes
    localparam logic [7:0] HDR_Q_CUR    = 8'h01;
    localparam logic [7:0] HDR_Q_SPD    = 8'h02;
    localparam logic [7:0] HDR_SPD_SETPT = 8'h03;
    localparam logic [7:0] HDR_SPD_KP   = 8'h04;
    localparam logic [7:0] HDR_SET_KP   = 8'h05;
    localparam logic [7:0] HDR_SET_KI   = 8'h06;
    localparam logic [7:0] HDR_SET_MODE = 8'h07;
    localparam logic [7:0] HDR_SET_SETPT = 8'h08;
    localparam logic [7:0] HDR_SPD_KI   = 8'h09;
    localparam logic [7:0] HDR_SET_DUTY = 8'h0A;
    localparam logic [7:0] HDR_Q_MODE   = 8'h0B;
    localparam logic [7:0] HDR_Q_TMP    = 8'h0C;

    // Accumulator layout: signed, 16 fraction bits, 48 bits wide
    localparam int     FRAC       = 16;
    localparam longint ACC_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN    = -ACC_MAX - 1;
    localparam longint ACC_ONE    = longint'(1) <<< FRAC;
    localparam longint ACC_CEIL   = longint'(256) <<< FRAC;
    localparam longint ACC_255    = longint'(255) <<< FRAC;
    localparam int     ITEM_TOTAL = 2030;
    localparam int     HOLD_AT    = 600;
    localparam int     HOLD_LEN   = 300;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    in_item_t in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    result_t  out_data;

    motor_current_pi_with_command_parser_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Controller image, advanced once per accepted input transfer
    logic [7:0]         mode_reg;
    logic               arg_pending;
    logic [7:0]         header;
    logic [7:0]         setpt;
    logic [23:0]        kp_gain;
    logic [23:0]        ki_gain;
    logic signed [8:0]  last_err;
    logic signed [47:0] accum;
    logic [7:0]         duty_reg;
    logic [7:0]         tx_reg;
    logic               led_reg;
    logic [7:0]         drive_duty;

    in_item_t cmd_stream[$];
    result_t  predicted_outputs[$];
    int       mismatches = 0;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic run_header(input logic [7:0] arg, input in_item_t it);
        case (header)
            HDR_Q_CUR:     tx_reg = it.current_sample;
            HDR_Q_SPD:     tx_reg = it.speed_sample;
            HDR_Q_TMP:     tx_reg = it.temp_sample;
            HDR_Q_MODE:    tx_reg = mode_reg;
            HDR_SET_KP:    kp_gain = 24'(arg) << FRAC;
            HDR_SET_KI:    ki_gain = 24'(arg) << FRAC;
            HDR_SET_MODE:  mode_reg = arg;
            HDR_SET_SETPT: setpt = arg;
            HDR_SET_DUTY:  duty_reg = arg;
            default:       ;   // speed loop and unknown headers: acknowledge only
        endcase
    endtask

    task automatic predict_item(input in_item_t it, output result_t r);
        logic signed [8:0] err;
        longint            kp;
        longint            k1;
        longint            acc;
        logic              alarm;
        alarm = 1'b0;
        if (!it.mode)
        begin
            tx_reg = TX_ACK;
            if (!arg_pending)
            begin
                header      = it.rx_byte;
                arg_pending = 1'b1;
                // queries answer on the header byte already
                if (header == HDR_Q_CUR || header == HDR_Q_SPD ||
                    header == HDR_Q_TMP || header == HDR_Q_MODE)
                    run_header(8'h00, it);
            end
            else
            begin
                arg_pending = 1'b0;
                run_header(it.rx_byte, it);
            end
        end
        else
        begin
            case (mode_reg)
                MODE_AUTO:
                begin
                    err = $signed({1'b0, setpt}) - $signed({1'b0, it.current_sample});
                    kp  = longint'(kp_gain);
                    k1  = kp + longint'(ki_gain);
                    acc = longint'(accum) + k1 * longint'(err) - kp * longint'(last_err);
                    if (acc > ACC_MAX)
                        acc = ACC_MAX;
                    if (acc < ACC_MIN)
                        acc = ACC_MIN;
                    // clamp the accumulator together with the duty
                    if (acc >= ACC_CEIL)
                    begin
                        duty_reg = 8'd255;
                        acc      = ACC_255;
                    end
                    else if (acc < ACC_ONE)
                    begin
                        duty_reg = 8'd1;
                        acc      = ACC_ONE;
                    end
                    else
                        duty_reg = 8'(acc >>> FRAC);
                    accum      = 48'(acc);
                    drive_duty = duty_reg;
                    last_err   = err;
                end
                MODE_MANUAL:
                begin
                    drive_duty = duty_reg;
                    led_reg    = 1'b1;
                end
                MODE_FAIL:
                begin
                    drive_duty = 8'd0;
                    last_err   = '0;
                    tx_reg     = TX_FAIL;
                end
                default:
                begin
                    alarm   = 1'b1;
                    led_reg = 1'b0;
                end
            endcase
        end
        r.duty        = drive_duty;
        r.tx_byte     = tx_reg;
        r.led_on      = led_reg;
        r.blink_alarm = alarm;
    endtask

    task automatic push_byte(input logic [7:0] b);
        in_item_t it;
        it.mode           = 1'b0;
        it.rx_byte        = b;
        it.current_sample = 8'($urandom);
        it.speed_sample   = 8'($urandom);
        it.temp_sample    = 8'($urandom);
        cmd_stream.push_back(it);
    endtask

    task automatic push_tick(input logic [7:0] cur);
        in_item_t it;
        it.mode           = 1'b1;
        it.rx_byte        = 8'($urandom);
        it.current_sample = cur;
        it.speed_sample   = 8'($urandom);
        it.temp_sample    = 8'($urandom);
        cmd_stream.push_back(it);
    endtask

    // Driver: offer queued items, idle in random bursts, predict on every transfer
    int unsigned send_gap = 0;
    int          sent_count = 0;
    logic        quiet = 1'b0;
    result_t     next_result;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            send_gap   = 0;
            sent_count <= 0;
            quiet      <= 1'b0;
            mode_reg    = MODE_MANUAL;
            arg_pending = 1'b0;
            header      = 8'h00;
            setpt       = SETPOINT_RESET;
            kp_gain     = 24'd6816;   // 0.1040 in Q8.16
            ki_gain     = 24'd439;    // 0.0067 in Q8.16
            last_err    = '0;
            accum       = '0;
            duty_reg    = 8'd0;
            tx_reg      = TX_ACK;
            led_reg     = 1'b0;
            drive_duty  = 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_item(in_data, next_result);
                predicted_outputs.push_back(next_result);
                sent_count <= sent_count + 1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 16);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0 || cmd_stream.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= cmd_stream.pop_front();
                end
            end
            // drop all idling near the end, and in every third stretch of transfers
            quiet     <= (cmd_stream.size() < 150) || ((sent_count / 128) % 3 == 0);
        end
    end

    // Long receiver hold-off: fill the queue and stall the input side
    int   hold_left = 0;
    logic hold_started = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            hold_started <= 1'b0;
        end
        else if (!hold_started && sent_count >= HOLD_AT)
        begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_LEN;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    int unsigned stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else if (hold_left > 0)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: check every output transfer against the oldest prediction
    result_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_outputs.size() == 0)
                flag_mismatch("output transfer with nothing predicted");
            else
            begin
                want = predicted_outputs.pop_front();
                if (out_data.duty !== want.duty)
                    flag_mismatch($sformatf("duty %0d, predicted %0d",
                                            out_data.duty, want.duty));
                if (out_data.tx_byte !== want.tx_byte)
                    flag_mismatch($sformatf("tx_byte %02h, predicted %02h",
                                            out_data.tx_byte, want.tx_byte));
                if (out_data.led_on !== want.led_on)
                    flag_mismatch($sformatf("led_on %b, predicted %b",
                                            out_data.led_on, want.led_on));
                if (out_data.blink_alarm !== want.blink_alarm)
                    flag_mismatch($sformatf("blink_alarm %b, predicted %b",
                                            out_data.blink_alarm, want.blink_alarm));
            end
        end
    end

    initial
    begin
        int         pick;
        int         cur;
        logic [7:0] hdr;
        logic [7:0] arg;
        logic [7:0] gen_setpt;

        // Directed opening
        push_tick(8'h00);                                   // manual tick out of reset
        push_byte(HDR_Q_CUR);     push_byte(8'hFF);         // query answers twice
        push_byte(HDR_Q_SPD);     push_byte(HDR_Q_TMP);
        push_byte(HDR_Q_TMP);     push_byte(HDR_Q_SPD);
        push_byte(HDR_Q_MODE);    push_byte(8'h00);
        push_byte(HDR_SET_DUTY);  push_byte(8'hFF);
        push_tick(8'h80);                                   // manual drives 255
        push_byte(HDR_SET_MODE);  push_byte(MODE_AUTO);
        push_tick(8'hFF);                                   // large negative error: floor at 1
        push_tick(8'h00);                                   // default gains, unclamped duty
        push_byte(HDR_SET_KP);    push_byte(8'hFF);
        push_tick(8'h00);                                   // huge gain, unchanged error: duty stays unclamped
        push_byte(HDR_SET_KI);    push_byte(8'h00);
        push_byte(HDR_SET_SETPT); push_byte(8'h00);
        push_byte(HDR_SET_MODE);  push_byte(MODE_FAIL);
        push_tick(8'h55);
        push_byte(HDR_SET_MODE);  push_byte(8'h99);
        push_tick(8'hAA);                                   // unknown mode: blink alarm

        // Random part: mostly well-formed commands and ticks, some noise
        gen_setpt = 8'h00;
        while (cmd_stream.size() < ITEM_TOTAL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || pick >= 94)
            begin
                for (int n = (pick < 40) ? 1 : $urandom_range(2, 5); n > 0; n--)
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_tick(8'($urandom));
                    else
                    begin
                        cur = int'(gen_setpt) + $urandom_range(0, 12) - 6;
                        cur = (cur < 0) ? 0 : (cur > 255) ? 255 : cur;
                        push_tick(8'(cur));
                    end
                end
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 11))
                    0:  hdr = HDR_Q_CUR;
                    1:  hdr = HDR_Q_SPD;
                    2:  hdr = HDR_Q_TMP;
                    3:  hdr = HDR_Q_MODE;
                    4:  hdr = HDR_SET_KP;
                    5:  hdr = HDR_SET_KI;
                    6:  hdr = HDR_SET_MODE;
                    7:  hdr = HDR_SET_SETPT;
                    8:  hdr = HDR_SET_DUTY;
                    9:  hdr = HDR_SPD_SETPT;
                    10: hdr = HDR_SPD_KP;
                    default: hdr = HDR_SPD_KI;
                endcase
                arg = 8'($urandom);
                if ((hdr == HDR_SET_KP || hdr == HDR_SET_KI) && $urandom_range(0, 7) != 0)
                    arg = 8'($urandom_range(0, 3));
                if (hdr == HDR_SET_MODE)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 10)
                        arg = MODE_AUTO;
                    else if (pick < 14)
                        arg = MODE_MANUAL;
                    else if (pick < 17)
                        arg = MODE_FAIL;
                end
                if (hdr == HDR_SET_SETPT)
                    gen_setpt = arg;
                push_byte(hdr);
                push_byte(arg);
            end
            else if (pick < 88)
            begin
                // unknown header with an argument
                push_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(8'h0D, 8'hFF)));
                push_byte(8'($urandom));
            end
            else
                push_byte(8'($urandom));                    // lone byte: shifts the parser
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_stream.size() != 0 || in_valid)
            @(posedge clk);
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
